[src/pee_pkg.sv]
// Package for the postfix expression evaluator: symbol codes, status codes,
// controller command/status structs. No dependencies.
package pee_pkg;
	localparam int STACK_DEPTH_DEF = 16;
	localparam logic [7:0] SYM_ADD = 8'h2B;
	localparam logic [7:0] SYM_SUB = 8'h2D;
	localparam logic [7:0] SYM_MUL = 8'h2A;
	localparam logic [7:0] SYM_DIV = 8'h2F;
	localparam logic [7:0] SYM_SQRT = 8'h73;
	localparam logic [7:0] SYM_CUBE = 8'h63;
	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_NINE = 8'h39;
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_UNKNOWN = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_DIVZERO = 3'd4;
	localparam logic [2:0] ST_NEGROOT = 3'd5;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_SQRT = 3'd4;
	localparam logic [2:0] OP_CUBE = 3'd5;

	typedef struct packed {
		logic       load;     // capture symbol, last
		logic       rd_top;   // read top entry
		logic       rd_second;
		logic       lat_b;    // latch read data as b
		logic       lat_a;
		logic       start;    // start iterative unit
		logic       mul_step; // result step (every op; two passes for c)
		logic       push;     // write digit
		logic       wr_res;   // write result
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic       busy;
		logic       done;
	} sts_t;
endpackage

[src/pee_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[src/pee_iter.sv]
// Shared iterative unit: 32-bit unsigned restoring divide and integer square
// root, one bit or one bit pair per cycle. Depends on pee_pkg.
module pee_iter import pee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_sqrt,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        busy,
	output logic [31:0] result
);
	logic [5:0]  cnt_q;
	logic        sq_q;
	logic [31:0] x_q, rem_q, quo_q, d_q;
	logic [32:0] trial;
	logic [33:0] strial;
	logic [33:0] srem;

	always_comb begin
		trial = {rem_q, x_q[31]} - {1'b0, d_q};
		srem = {rem_q, x_q[31:30]};
		strial = srem - {quo_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= is_sqrt ? 6'd16 : 6'd32;
		end else if (cnt_q != 0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sq_q <= is_sqrt;
			x_q <= a;
			d_q <= b;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != 0) begin
			if (sq_q) begin
				x_q <= {x_q[29:0], 2'b00};
				if (!strial[33]) begin
					rem_q <= strial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= srem[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end else begin
				x_q <= {x_q[30:0], 1'b0};
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], x_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
		end
	end

	assign busy = (cnt_q != 0);
	assign result = quo_q;
endmodule

[src/pee_datapath.sv]
// Datapath: value stack RAM, operand registers, ALU, iterative unit, output.
// Depends on pee_pkg, pee_ram, pee_iter.
module pee_datapath import pee_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           cmd,
	input  logic [2:0]                     op,
	input  logic [$clog2(STACK_DEPTH)-1:0] top_idx,
	input  logic [$clog2(STACK_DEPTH)-1:0] wr_idx,
	input  logic [7:0]                     sym,
	input  logic                           out_ok,
	input  logic [2:0]                     out_status,
	output logic                           b_zero,
	output logic                           b_neg,
	output logic                           iter_busy,
	output logic signed [31:0]             value,
	output logic [2:0]                     status
);
	localparam int AW = $clog2(STACK_DEPTH);
	logic [31:0] rdata, a_q, b_q, r_q, wdata, ma, mb, res;
	logic [AW-1:0] raddr;
	logic        neg_q, iq;

	assign raddr = cmd.rd_second ? top_idx - AW'(1) : top_idx;
	assign wdata = cmd.push ? {28'd0, sym[3:0] - SYM_ZERO[3:0]} : r_q;

	pee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
		.clk(clk), .we(cmd.push | cmd.wr_res), .waddr(wr_idx), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign ma = a_q[31] ? 32'd0 - a_q : a_q;
	assign mb = b_q[31] ? 32'd0 - b_q : b_q;
	assign iq = (op == OP_SQRT);

	pee_iter u_iter (
		.clk(clk), .arst_n(arst_n), .start(cmd.start), .is_sqrt(iq),
		.a(iq ? b_q : ma), .b(mb), .busy(iter_busy), .result(res)
	);

	assign b_zero = (b_q == 32'd0);
	assign b_neg = b_q[31];

	always_ff @(posedge clk) begin
		if (cmd.lat_b) b_q <= rdata;
		if (cmd.lat_a) a_q <= rdata;
		if (cmd.start) neg_q <= a_q[31] ^ b_q[31];
		if (cmd.mul_step) begin
			case (op)
				OP_ADD: r_q <= a_q + b_q;
				OP_SUB: r_q <= a_q - b_q;
				OP_MUL: r_q <= a_q * b_q;
				OP_CUBE: begin
					// second pass: a = x, b = x*x
					r_q <= a_q * b_q;
					a_q <= b_q;
					b_q <= b_q * b_q;
				end
				OP_DIV: r_q <= neg_q ? 32'd0 - res : res;
				OP_SQRT: r_q <= res;
				default: r_q <= r_q;
			endcase
		end
		if (cmd.out_load) begin
			value <= out_ok ? rdata : 32'd0;
			status <= out_status;
		end
	end
endmodule

[src/pee_ctrl.sv]
// Controller state machine: decode, stack count, error latch, output valid.
// Depends on pee_pkg.
module pee_ctrl import pee_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     symbol,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           b_zero,
	input  logic                           b_neg,
	input  logic                           iter_busy,
	output cmd_t                           cmd,
	output logic [2:0]                     op,
	output logic [$clog2(STACK_DEPTH)-1:0] top_idx,
	output logic [$clog2(STACK_DEPTH)-1:0] wr_idx,
	output logic [7:0]                     sym,
	output logic                           out_ok,
	output logic [2:0]                     out_status
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RDB = 4'd2, S_RDA = 4'd3,
		S_CHK = 4'd4, S_WAIT = 4'd5, S_CUBE2 = 4'd6, S_FIN = 4'd7, S_WR = 4'd8,
		S_END = 4'd9, S_OUT = 4'd10, S_CUBE3 = 4'd11;

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]    err_q, op_q;
	logic [7:0]    sym_q;
	logic          last_q, ov_q, bin;

	assign sym = sym_q;
	assign op = op_q;
	assign top_idx = AW'(cnt_q - CW'(1));
	assign wr_idx = (state_q == S_DEC) ? AW'(cnt_q) :
		(bin ? AW'(cnt_q - CW'(2)) : AW'(cnt_q - CW'(1)));
	assign bin = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_MUL) || (op_q == OP_DIV);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign out_ok = (err_q == ST_OK) && (cnt_q != 0);
	assign out_status = (err_q != ST_OK) ? err_q : ((cnt_q == 0) ? ST_UNDERFLOW : ST_OK);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_RDB: begin cmd.lat_b = 1'b1; cmd.rd_second = 1'b1; end
			S_RDA: begin
				cmd.lat_a = bin;
			end
			S_WAIT: cmd.mul_step = !iter_busy;
			S_CUBE2: cmd.mul_step = 1'b1;
			S_WR: cmd.wr_res = 1'b1;
			S_OUT: cmd.out_load = 1'b1;
			default: cmd = '0;
		endcase
		if (state_q == S_DEC && err_q == ST_OK && sym_q >= SYM_ZERO && sym_q <= SYM_NINE
			&& cnt_q < CW'(STACK_DEPTH))
			cmd.push = 1'b1;
		if (state_q == S_FIN && (op_q == OP_DIV || op_q == OP_SQRT)) cmd.start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			err_q <= ST_OK;
			ov_q <= 1'b0;
			op_q <= OP_ADD;
			sym_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					sym_q <= symbol;
					last_q <= last;
					state_q <= S_DEC;
				end
				S_DEC: begin
					state_q <= last_q ? S_END : S_IDLE;
					if (err_q == ST_OK) begin
						if (sym_q >= SYM_ZERO && sym_q <= SYM_NINE) begin
							if (cnt_q < CW'(STACK_DEPTH)) cnt_q <= cnt_q + CW'(1);
							else err_q <= ST_OVERFLOW;
						end else begin
							case (sym_q)
								SYM_ADD: op_q <= OP_ADD;
								SYM_SUB: op_q <= OP_SUB;
								SYM_MUL: op_q <= OP_MUL;
								SYM_DIV: op_q <= OP_DIV;
								SYM_SQRT: op_q <= OP_SQRT;
								SYM_CUBE: op_q <= OP_CUBE;
								default: op_q <= op_q;
							endcase
							if (sym_q == SYM_SQRT || sym_q == SYM_CUBE) begin
								if (cnt_q == 0) err_q <= ST_UNDERFLOW;
								else state_q <= S_RDB;
							end else if (sym_q == SYM_ADD || sym_q == SYM_SUB ||
								sym_q == SYM_MUL || sym_q == SYM_DIV) begin
								if (cnt_q < CW'(2)) err_q <= ST_UNDERFLOW;
								else state_q <= S_RDB;
							end else begin
								err_q <= ST_UNKNOWN;
							end
						end
					end
				end
				S_RDB: state_q <= S_RDA;
				S_RDA: state_q <= S_CHK;
				S_CHK: begin
					if (op_q == OP_DIV && b_zero) begin
						err_q <= ST_DIVZERO;
						state_q <= last_q ? S_END : S_IDLE;
					end else if (op_q == OP_SQRT && b_neg) begin
						err_q <= ST_NEGROOT;
						state_q <= last_q ? S_END : S_IDLE;
					end else state_q <= S_FIN;
				end
				S_FIN: state_q <= S_WAIT;
				S_WAIT: if (!iter_busy) state_q <= (op_q == OP_CUBE) ? S_CUBE2 : S_WR;
				S_CUBE2: state_q <= S_WR;
				S_WR: begin
					if (bin) cnt_q <= cnt_q - CW'(1);
					state_q <= last_q ? S_CUBE3 : S_IDLE;
				end
				S_CUBE3: state_q <= S_END;
				S_END: begin
					// wait for the output register to drain
					if (!ov_q) state_q <= S_OUT;
				end
				S_OUT: begin
					ov_q <= 1'b1;
					cnt_q <= '0;
					err_q <= ST_OK;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[src/postfix_expression_evaluator_top.sv]
// Top level of the postfix expression evaluator.
// Depends on pee_pkg, pee_ctrl, pee_datapath.
//
// Input channel: symbol, last with in_valid/in_ready. One item per
// character; the item with last set produces one result on the output
// channel (value, status with out_valid/out_ready).
// The shift-subtract unit shared by s and / does one root bit (16 steps)
// or one quotient bit (32 steps) per cycle. A zero divisor or a negative
// root is caught in S_CHK, before that unit starts. out_valid rises after
// a final digit or ignored character passes S_DEC, S_END and S_OUT, and
// after a final operator passes S_WR, S_CUBE3, S_END and S_OUT.
// The result is held in an output register. While the receiver stalls,
// input keeps flowing; the next final item waits ahead of the output
// register until it is taken, and input stops meanwhile.
// Reset clears the stack count, the error latch and the output valid;
// stack contents are undefined and only ever read below the count.
// After each result the stack and error are cleared.
module postfix_expression_evaluator_top import pee_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         symbol,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic [2:0]         status
);
	localparam int AW = $clog2(STACK_DEPTH);
	cmd_t cmd;
	logic [2:0] op, out_status;
	logic [AW-1:0] top_idx, wr_idx;
	logic [7:0] sym;
	logic b_zero, b_neg, iter_busy, out_ok;

	pee_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.symbol(symbol), .last(last), .out_valid(out_valid), .out_ready(out_ready),
		.b_zero(b_zero), .b_neg(b_neg), .iter_busy(iter_busy), .cmd(cmd), .op(op),
		.top_idx(top_idx), .wr_idx(wr_idx), .sym(sym), .out_ok(out_ok),
		.out_status(out_status)
	);

	pee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .op(op), .top_idx(top_idx),
		.wr_idx(wr_idx), .sym(sym), .out_ok(out_ok), .out_status(out_status),
		.b_zero(b_zero), .b_neg(b_neg), .iter_busy(iter_busy), .value(value),
		.status(status)
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(value) && $stable(status)))
		else $error("result dropped or changed while stalled");
	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> value == 32'sd0) else $error("error value");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !iter_busy) else $error("iterative unit restarted");
endmodule
